// File: rtl/qpsa_pkg.sv
// ----------------------------------------------------------------------------
// qpsa_pkg
// Shared types and constants for the quadratic probing slot allocator.
// ----------------------------------------------------------------------------
package qpsa_pkg;

    // Fixed field widths of one item and one result.
    localparam int KEY_W    = 31;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 4;

    // The four key bytes fold into a sum that stays below 2**16 for up to
    // 64 slots. The reciprocal of the slot count needs two bits more.
    localparam int FOLD_W = 16;
    localparam int RCP_W  = FOLD_W + 2;

    // Waiting counts saturate here.
    localparam logic [DEPTH_W-1:0] WAIT_MAX = 4'd15;

    // Operation codes.
    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_WAIT  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WAITING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_QUOT,
        S_REM,
        S_HOME,
        S_PROBE,
        S_READ,
        S_WB
    } state_t;

endpackage

// File: rtl/quadratic_probe_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// quadratic_probe_slot_allocator_unit
// Two-store slot allocator with quadratic probing and per-slot waiting counts.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Ports
//  -------   ----------------   ------------------------------------------
//  item in   start && !busy     op, store_sel, key
//  result    done (one cycle)   slot, status, home_taken, wait_depth
//
//  An accepted item has its key reduced modulo SLOTS in S_FOLD, S_QUOT and
//  S_REM: the four key bytes are folded with the constant residues of their
//  weights into a 16-bit sum, a reciprocal multiplication gives the quotient
//  of that sum, and a constant multiply and subtract leaves the home slot.
//  The home slot is then checked in S_HOME. A place request walks the probe
//  sequence at one slot per cycle, for up to SLOTS-1 probes. The waiting
//  count memory is read in S_READ and written back in S_WB for a waiting
//  result. busy is high from the cycle after acceptance and falls in the
//  cycle in which done is high; a new item may be accepted then, and not
//  before the block is through with the last one. Reset clears the occupancy
//  bits and the waiting-count valid bits at once, so no clearing pass is
//  needed. The receiver cannot stall the result.
//
module quadratic_probe_slot_allocator_unit
    import qpsa_pkg::*;
#(
    parameter int SLOTS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic                store_sel,
    input  logic [KEY_W-1:0]    key,
    output logic                done,
    output logic [SLOT_W-1:0]   slot,
    output logic [STATUS_W-1:0] status,
    output logic                home_taken,
    output logic [DEPTH_W-1:0]  wait_depth
);

    // Width of a slot number and of a waiting-memory address.
    localparam int SW      = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int ENTRIES = 2 * SLOTS;
    localparam int AW      = $clog2(ENTRIES);

    // Residues of the weights of key bytes one to three modulo SLOTS.
    localparam logic [FOLD_W-1:0] WT1 = FOLD_W'((1 << 8) % SLOTS);
    localparam logic [FOLD_W-1:0] WT2 = FOLD_W'((1 << 16) % SLOTS);
    localparam logic [FOLD_W-1:0] WT3 = FOLD_W'((1 << 24) % SLOTS);

    // Rounded-up reciprocal of SLOTS. With a shift of FOLD_W + ceil(log2
    // SLOTS) the quotient is exact for every FOLD_W-bit dividend.
    localparam int                PROD_W  = FOLD_W + RCP_W;
    localparam int                RCP_SH  = FOLD_W + SW;
    localparam logic [RCP_W-1:0]  RECIP   =
        RCP_W'(((64'd1 << RCP_SH) + 64'(SLOTS - 1)) / 64'(SLOTS));
    localparam logic [FOLD_W-1:0] SLOTS_F = FOLD_W'(SLOTS);

    localparam logic [SW:0]          SLOTS_W1   = (SW + 1)'(SLOTS);
    localparam logic [SW-1:0]        LAST_PROBE = SW'(SLOTS - 2);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic                   op_reg, op_next;
    logic                   store_reg, store_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [FOLD_W-1:0]      fold_reg, fold_next;
    logic [FOLD_W-1:0]      quot_reg, quot_next;
    logic [SW-1:0]          rem_reg, rem_next;
    logic [SW-1:0]          probe_reg, probe_next;
    logic [SW-1:0]          inc_reg, inc_next;
    logic [SW-1:0]          att_reg, att_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                   home_taken_reg, home_taken_next;

    logic [SLOTS-1:0]       occ_reg [2];
    logic [SLOTS-1:0]       occ_next [2];
    logic [ENTRIES-1:0]     wvalid_reg, wvalid_next;

    logic                   done_reg, done_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   home_out_reg, home_out_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;

    // Waiting-count memory with a registered read port.
    logic [DEPTH_W-1:0]     wait_mem [ENTRIES];
    logic [DEPTH_W-1:0]     mem_rdata_reg;
    logic                   mem_rd_en;
    logic                   mem_wr_en;
    logic [DEPTH_W-1:0]     mem_wdata;
    logic [AW-1:0]          mem_addr;

    // ------------------------------------------------------------------
    // Combinational datapath pieces
    // ------------------------------------------------------------------
    logic [FOLD_W-1:0]      fold_sum;
    logic [PROD_W-1:0]      quot_prod;
    logic [FOLD_W-1:0]      rem_full;
    logic [SW:0]            probe_sum;
    logic [SW:0]            inc_sum;
    logic                   probe_busy;
    logic                   home_busy;
    logic [DEPTH_W-1:0]     cur_depth;
    logic [DEPTH_W-1:0]     inc_depth;
    logic [SW+3:0]          slot_ext;

    // Each key byte is weighted by its residue, which keeps the sum congruent
    // to the key and below 2**16 for up to 64 slots.
    assign fold_sum = FOLD_W'(key_reg[7:0])
                    + FOLD_W'(key_reg[15:8]) * WT1
                    + FOLD_W'(key_reg[23:16]) * WT2
                    + FOLD_W'(key_reg[KEY_W-1:24]) * WT3;

    // The quotient of the folded sum, then what is left after removing it.
    assign quot_prod = PROD_W'(fold_reg) * PROD_W'(RECIP);
    assign rem_full  = fold_reg - quot_reg * SLOTS_F;

    // The probe offset grows by 2a+1 between attempts, so the next slot is
    // one add with a wrap and the step itself grows by two with a wrap.
    assign probe_sum = {1'b0, probe_reg} + {1'b0, inc_reg};
    assign inc_sum   = {1'b0, inc_reg} + (SW + 1)'(2);

    assign probe_busy = occ_reg[store_reg][probe_reg];
    assign home_busy  = occ_reg[store_reg][rem_reg];

    assign mem_addr  = (store_reg ? AW'(SLOTS) : AW'(0)) + AW'(probe_reg);
    assign cur_depth = wvalid_reg[mem_addr] ? mem_rdata_reg : '0;
    assign inc_depth = (cur_depth == WAIT_MAX) ? WAIT_MAX : cur_depth + DEPTH_W'(1);
    assign slot_ext  = {4'b0000, probe_reg};

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        store_next      = store_reg;
        key_next        = key_reg;
        fold_next       = fold_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        probe_next      = probe_reg;
        inc_next        = inc_reg;
        att_next        = att_reg;
        res_status_next = res_status_reg;
        home_taken_next = home_taken_reg;
        occ_next        = occ_reg;
        wvalid_next     = wvalid_reg;
        done_next       = 1'b0;
        slot_next       = slot_reg;
        status_next     = status_reg;
        home_out_next   = home_out_reg;
        depth_next      = depth_reg;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wdata       = inc_depth;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    store_next = store_sel;
                    key_next   = key;
                    state_next = S_FOLD;
                end
            end

            S_FOLD:
            begin
                fold_next  = fold_sum;
                state_next = S_QUOT;
            end

            S_QUOT:
            begin
                quot_next  = FOLD_W'(quot_prod >> RCP_SH);
                state_next = S_REM;
            end

            S_REM:
            begin
                rem_next   = rem_full[SW-1:0];
                state_next = S_HOME;
            end

            S_HOME:
            begin
                home_taken_next = home_busy;
                probe_next      = rem_reg;
                inc_next        = SW'(1);
                att_next        = '0;
                if (op_reg == OP_WAIT)
                begin
                    res_status_next = home_busy ? ST_WAITING : ST_PLACED;
                    state_next      = S_READ;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (!probe_busy)
                begin
                    res_status_next = ST_PLACED;
                    state_next      = S_READ;
                end
                else if (att_reg == LAST_PROBE)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_WB;
                end
                else
                begin
                    att_next   = att_reg + SW'(1);
                    probe_next = (probe_sum >= SLOTS_W1) ? SW'(probe_sum - SLOTS_W1)
                                                         : probe_sum[SW-1:0];
                    inc_next   = (inc_sum >= SLOTS_W1) ? SW'(inc_sum - SLOTS_W1)
                                                       : inc_sum[SW-1:0];
                end
            end

            S_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_WB;
            end

            S_WB:
            begin
                done_next     = 1'b1;
                status_next   = res_status_reg;
                home_out_next = home_taken_reg;
                case (res_status_reg)
                    ST_WAITING:
                    begin
                        mem_wr_en             = 1'b1;
                        wvalid_next[mem_addr] = 1'b1;
                        slot_next             = slot_ext[SLOT_W-1:0];
                        depth_next            = inc_depth;
                    end
                    ST_PLACED:
                    begin
                        occ_next[store_reg][probe_reg] = 1'b1;
                        slot_next                      = slot_ext[SLOT_W-1:0];
                        depth_next                     = cur_depth;
                    end
                    default:
                    begin
                        slot_next  = '0;
                        depth_next = '0;
                    end
                endcase
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg[0] <= '0;
            occ_reg[1] <= '0;
            wvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            wvalid_reg <= wvalid_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        store_reg      <= store_next;
        key_reg        <= key_next;
        fold_reg       <= fold_next;
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        probe_reg      <= probe_next;
        inc_reg        <= inc_next;
        att_reg        <= att_next;
        res_status_reg <= res_status_next;
        home_taken_reg <= home_taken_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        home_out_reg   <= home_out_next;
        depth_reg      <= depth_next;
    end

    // Waiting-count memory.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            wait_mem[mem_addr] <= mem_wdata;
        end
        if (mem_rd_en)
        begin
            mem_rdata_reg <= wait_mem[mem_addr];
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign slot       = slot_reg;
    assign status     = status_reg;
    assign home_taken = home_out_reg;
    assign wait_depth = depth_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (slot == '0 && wait_depth == '0))
        else $error("full result carries a slot or a depth");

    a_wait_home: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_WAITING) |-> home_taken)
        else $error("waiting result on a free home slot");

    a_occ_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_reg[0] & $past(occ_reg[0])) == $past(occ_reg[0]))
        && ((occ_reg[1] & $past(occ_reg[1])) == $past(occ_reg[1])))
        else $error("an occupied slot was released");

endmodule
